// ===== rtl/u8d_pkg.sv =====
// Shared types and constants of the UTF-8 stream decoder.
package u8d_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_CHAR = 2'd0,
		ST_REPL = 2'd1,
		ST_FAIL = 2'd2
	} status_t;

	localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [7:0]  CONT_LO        = 8'h80;
	localparam logic [7:0]  CONT_HI        = 8'hBF;
	localparam logic [7:0]  LEAD2_LO       = 8'hC2;
	localparam logic [7:0]  LEAD2_HI       = 8'hDF;
	localparam logic [7:0]  LEAD3_LO       = 8'hE0;
	localparam logic [7:0]  LEAD3_HI       = 8'hEF;
	localparam logic [7:0]  LEAD3_SURR     = 8'hED;
	localparam logic [7:0]  LEAD4_LO       = 8'hF0;
	localparam logic [7:0]  LEAD4_HI       = 8'hF4;
	localparam logic [7:0]  E0_SECOND_LO   = 8'hA0;
	localparam logic [7:0]  ED_SECOND_HI   = 8'h9F;
	localparam logic [7:0]  F0_SECOND_LO   = 8'h90;
	localparam logic [7:0]  F4_SECOND_HI   = 8'h8F;

	// Result queue geometry
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	// Decoder state between items
	typedef struct packed {
		logic [20:0] pv;
		logic [1:0]  need;
		logic        first;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic        failed;
	} dec_state_t;

	localparam dec_state_t DEC_IDLE = '{
		pv: 21'd0, need: 2'd0, first: 1'b0, lo: CONT_LO, hi: CONT_HI, failed: 1'b0
	};

	typedef struct packed {
		logic [20:0] cp;
		status_t     st;
		logic        last;
	} result_t;

	// Up to two results of one item, in order
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} res_pair_t;

	// Result queue status toward the input side
	typedef struct packed {
		logic [QCNT_W-1:0] level;
		logic              room;
	} q_stat_t;

endpackage

// ===== rtl/u8d_decode.sv =====
// Per-item decode logic: next decoder state and up to two results.
module u8d_decode (
	input  u8d_pkg::dec_state_t cur,
	input  logic [7:0]          data_byte,
	input  logic                has_byte,
	input  logic                finish,
	input  logic                fatal_mode,
	output u8d_pkg::dec_state_t nxt,
	output u8d_pkg::res_pair_t  res
);
	import u8d_pkg::*;

	typedef struct packed {
		logic        emit;
		result_t     r;
		logic        fail;
		logic [20:0] pv;
		logic [1:0]  need;
		logic        first;
		logic [7:0]  lo;
		logic [7:0]  hi;
	} lead_t;

	// Append one result; a third result is dropped
	function automatic res_pair_t push_res(res_pair_t p, logic [20:0] cp, status_t st);
		res_pair_t q;
		q = p;
		case (p.cnt)
			2'd0: begin
				q.r0.cp = cp;
				q.r0.st = st;
				q.cnt   = 2'd1;
			end
			2'd1: begin
				q.r1.cp = cp;
				q.r1.st = st;
				q.cnt   = 2'd2;
			end
			default: ;
		endcase
		return q;
	endfunction

	// Decode a byte seen while no sequence is open
	function automatic lead_t take_lead(logic [7:0] b, logic fatal);
		lead_t l;
		l = '0;
		l.lo   = CONT_LO;
		l.hi   = CONT_HI;
		l.r.st = ST_CHAR;
		if (b < CONT_LO) begin
			l.emit = 1'b1;
			l.r.cp = {13'd0, b};
		end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			l.need  = 2'd1;
			l.first = 1'b1;
			l.pv    = {16'd0, b[4:0]};
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			l.need  = 2'd2;
			l.first = 1'b1;
			l.pv    = {17'd0, b[3:0]};
			if (b == LEAD3_LO) l.lo = E0_SECOND_LO;
			else if (b == LEAD3_SURR) l.hi = ED_SECOND_HI;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			l.need  = 2'd3;
			l.first = 1'b1;
			l.pv    = {18'd0, b[2:0]};
			if (b == LEAD4_LO) l.lo = F0_SECOND_LO;
			else if (b == LEAD4_HI) l.hi = F4_SECOND_HI;
		end else begin
			l.emit = 1'b1;
			if (fatal) begin
				l.r.cp = 21'd0;
				l.r.st = ST_FAIL;
				l.fail = 1'b1;
			end else begin
				l.r.cp = REPLACEMENT_CP;
				l.r.st = ST_REPL;
			end
		end
		return l;
	endfunction

	lead_t       ld;
	logic [7:0]  clo;
	logic [7:0]  chi;
	logic [20:0] pv_ext;
	logic [1:0]  need_dec;

	always_comb begin
		nxt      = cur;
		res      = '0;
		ld       = take_lead(data_byte, fatal_mode);
		clo      = cur.first ? cur.lo : CONT_LO;
		chi      = cur.first ? cur.hi : CONT_HI;
		pv_ext   = {cur.pv[14:0], data_byte[5:0]};
		need_dec = cur.need - 2'd1;

		if (!cur.failed) begin
			// Byte: lead, continuation or out-of-range continuation
			if (has_byte) begin
				if (cur.need == 2'd0) begin
					if (ld.emit) res = push_res(res, ld.r.cp, ld.r.st);
					nxt.failed = ld.fail;
					nxt.pv     = ld.pv;
					nxt.need   = ld.need;
					nxt.first  = ld.first;
					nxt.lo     = ld.lo;
					nxt.hi     = ld.hi;
				end else if (data_byte < clo || data_byte > chi) begin
					nxt = DEC_IDLE;
					if (fatal_mode) begin
						res        = push_res(res, 21'd0, ST_FAIL);
						nxt.failed = 1'b1;
					end else begin
						res = push_res(res, REPLACEMENT_CP, ST_REPL);
						if (ld.emit) res = push_res(res, ld.r.cp, ld.r.st);
						nxt.failed = ld.fail;
						nxt.pv     = ld.pv;
						nxt.need   = ld.need;
						nxt.first  = ld.first;
						nxt.lo     = ld.lo;
						nxt.hi     = ld.hi;
					end
				end else if (need_dec == 2'd0) begin
					res = push_res(res, pv_ext, ST_CHAR);
					nxt = DEC_IDLE;
				end else begin
					nxt.pv    = pv_ext;
					nxt.need  = need_dec;
					nxt.first = 1'b0;
				end
			end

			// Flush a pending prefix at end of stream
			if (finish && !nxt.failed && nxt.need != 2'd0) begin
				if (fatal_mode) res = push_res(res, 21'd0, ST_FAIL);
				else res = push_res(res, REPLACEMENT_CP, ST_REPL);
			end
		end

		// End of stream leaves the decoder idle and clears failure
		if (finish) nxt = DEC_IDLE;

		// Mark the final result of the item
		if (res.cnt == 2'd1) res.r0.last = 1'b1;
		if (res.cnt == 2'd2) res.r1.last = 1'b1;
	end

endmodule

// ===== rtl/u8d_result_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while the reader is ready.
module u8d_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8d_pkg::res_pair_t  din,
	output logic                out_valid,
	input  logic                out_ready,
	output u8d_pkg::result_t    dout,
	output u8d_pkg::q_stat_t    stat
);
	import u8d_pkg::*;

	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QPTR_W-1:0] wr_ptr_p1;
	logic [1:0]        n_in;
	logic              pop;

	assign wr_ptr_p1 = wr_ptr_q + QPTR_W'(1);
	assign n_in      = push ? din.cnt : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign dout      = mem_q[rd_ptr_q];
	assign stat.level = cnt_q;
	assign stat.room  = (cnt_q <= QCNT_W'(QDEPTH - 2));

	// Write entries
	always_ff @(posedge clk) begin
		if (n_in != 2'd0) mem_q[wr_ptr_q] <= din.r0;
		if (n_in == 2'd2) mem_q[wr_ptr_p1] <= din.r1;
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_in);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(n_in) - QCNT_W'(pop);
		end
	end

endmodule

// ===== rtl/utf8_stream_decoder_core.sv =====
// Top level of the UTF-8 stream decoder: input stage, decoder state, result queue.
// Takes one byte per item and returns Unicode scalar values, one U+FFFD per
// maximal ill-formed subpart (or a failure result in fatal mode). An item can
// be accepted every cycle while the queue has room. An accepted item is held in
// the input register and decoded into the four-entry result queue; its first
// result shows on the output port once it is written into the queue. An item
// gives zero, one or two results, and the output port delivers one result per
// cycle while the sink is ready, so items that give two results hold the input
// back when the queue fills: the input stalls while more than two results
// wait in the queue.
module utf8_stream_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,      // fatal_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // has_byte
	input  logic        s_axis_tlast,   // finish
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [20:0] scalar value, [23:21] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast    // last
);
	import u8d_pkg::*;

	logic       fatal_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_s1;
	logic       fin_s1;
	logic       adv;
	dec_state_t st_q;
	dec_state_t st_nxt;
	res_pair_t  res;
	result_t    q_out;
	q_stat_t    q_stat;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fatal_q <= 1'b0;
		else if (cfg_we) fatal_q <= cfg_wdata;
	end

	// Input stage
	assign adv           = valid_s1 && q_stat.room;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (s_axis_tready) valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			has_s1  <= s_axis_tuser;
			fin_s1  <= s_axis_tlast;
		end
	end

	u8d_decode u_decode (
		.cur        (st_q),
		.data_byte  (byte_s1),
		.has_byte   (has_s1),
		.finish     (fin_s1),
		.fatal_mode (fatal_q),
		.nxt        (st_nxt),
		.res        (res)
	);

	// Decoder state advances once per decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= DEC_IDLE;
		else if (adv) st_q <= st_nxt;
	end

	u8d_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.din       (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.dout      (q_out),
		.stat      (q_stat)
	);

	assign m_axis_tdata = {3'b000, q_out.cp};
	assign m_axis_tuser = q_out.st;
	assign m_axis_tlast = q_out.last;

	// Checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= QCNT_W'(QDEPTH))
		else $error("result queue overfilled");

	a_silent_after_fail: assert property (@(posedge clk) disable iff (!arst_n)
		adv && st_q.failed |-> res.cnt == 2'd0)
		else $error("result produced after fatal failure");

	a_idle_no_first: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.need == 2'd0 |-> !st_q.first)
		else $error("first continuation flagged with no open sequence");

	a_fail_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && q_out.st == ST_FAIL |-> q_out.cp == 21'd0)
		else $error("failure result carries a code point");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the UTF-8 stream decoder: stream driver, predictor and result checker.
`timescale 1ns / 100ps

module testbench;
	import u8d_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned LONG_HOLD   = 200;
	localparam int unsigned SETTLE      = 6;

	typedef struct packed {
		logic [7:0] b;
		logic       has;
		logic       fin;
	} byte_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// Decoder copy kept by the predictor
	logic [20:0] dec_pv     = '0;
	logic [1:0]  dec_need   = '0;
	logic        dec_first  = 1'b0;
	logic [7:0]  dec_lo     = CONT_LO;
	logic [7:0]  dec_hi     = CONT_HI;
	logic        dec_failed = 1'b0;
	logic        dec_fatal  = 1'b0;

	byte_item_t  pending_items[$];
	result_t     expected_results[$];
	result_t     item_res[$];
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned send_gap;
	int unsigned sink_stall;
	bit          calm_phase;
	bit          hold_wanted;
	bit          hold_done;

	utf8_stream_decoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void enter_idle();
		dec_pv    = '0;
		dec_need  = '0;
		dec_first = 1'b0;
		dec_lo    = CONT_LO;
		dec_hi    = CONT_HI;
	endfunction

	function automatic void add_result(logic [20:0] cp, status_t st);
		result_t r;
		r.cp   = cp;
		r.st   = st;
		r.last = 1'b0;
		item_res.insert(item_res.size(), r);
	endfunction

	// Report an ill-formed subpart; return 1 when the rest of the item is dropped
	function automatic bit ill_formed();
		enter_idle();
		if (dec_fatal) begin
			add_result('0, ST_FAIL);
			dec_failed = 1'b1;
			return 1'b1;
		end
		add_result(REPLACEMENT_CP, ST_REPL);
		return 1'b0;
	endfunction

	// Decode a byte seen outside a sequence
	function automatic void open_sequence(logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = CONT_LO;
		hi = CONT_HI;
		if (b < CONT_LO) begin
			add_result({13'd0, b}, ST_CHAR);
			return;
		end
		if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			dec_need = 2'd1;
			dec_pv   = {16'd0, b[4:0]};
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			dec_need = 2'd2;
			dec_pv   = {17'd0, b[3:0]};
			if (b == LEAD3_LO)
				lo = E0_SECOND_LO;
			else if (b == LEAD3_SURR)
				hi = ED_SECOND_HI;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			dec_need = 2'd3;
			dec_pv   = {18'd0, b[2:0]};
			if (b == LEAD4_LO)
				lo = F0_SECOND_LO;
			else if (b == LEAD4_HI)
				hi = F4_SECOND_HI;
		end else begin
			void'(ill_formed());
			return;
		end
		dec_first = 1'b1;
		dec_lo    = lo;
		dec_hi    = hi;
	endfunction

	// Work out the results of one accepted item and queue them
	function automatic void decode_item(logic [7:0] b, logic has, logic fin);
		logic [7:0] lo;
		logic [7:0] hi;
		item_res.delete();
		if (!dec_failed) begin
			if (has) begin
				if (dec_need == 2'd0) begin
					open_sequence(b);
				end else begin
					lo = dec_first ? dec_lo : CONT_LO;
					hi = dec_first ? dec_hi : CONT_HI;
					if (b < lo || b > hi) begin
						// close the subpart, then retry the same byte as a lead
						if (!ill_formed())
							open_sequence(b);
					end else begin
						dec_pv    = {dec_pv[14:0], b[5:0]};
						dec_first = 1'b0;
						dec_need  = dec_need - 2'd1;
						if (dec_need == 2'd0) begin
							add_result(dec_pv, ST_CHAR);
							enter_idle();
						end
					end
				end
			end
			if (fin && !dec_failed && dec_need != 2'd0)
				void'(ill_formed());
		end
		if (fin) begin
			enter_idle();
			dec_failed = 1'b0;
		end
		if (item_res.size() > 0)
			item_res[item_res.size() - 1].last = 1'b1;
		foreach (item_res[i])
			expected_results.insert(expected_results.size(), item_res[i]);
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic void add_item(logic [7:0] b, logic has, logic fin);
		byte_item_t it;
		it.b   = b;
		it.has = has;
		it.fin = fin;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm_phase)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Pick a byte in a range, leaning toward its ends
	function automatic logic [7:0] pick_in(logic [7:0] lo, logic [7:0] hi);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15)
			return lo;
		if (r < 30)
			return hi;
		return 8'($urandom_range(hi, lo));
	endfunction

	// Queue one run: noise, an empty item, ASCII, a full sequence or a broken one
	function automatic void add_random_run(int unsigned fin_pct);
		logic [7:0]  lead;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [7:0]  run[$];
		int unsigned span;
		int unsigned keep;
		int unsigned r;
		logic        fin;
		r   = $urandom_range(99);
		fin = ($urandom_range(99) < fin_pct);
		if (r < 10) begin
			add_item(8'($urandom_range(255)), 1'b1, fin);
			return;
		end
		if (r < 15) begin
			add_item(8'($urandom_range(255)), 1'b0, fin);
			return;
		end
		if (r < 30) begin
			add_item(8'($urandom_range(127)), 1'b1, fin);
			return;
		end
		// pick a lead, often one that narrows the second-byte range
		case ($urandom_range(3))
			0: lead = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
			1: lead = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
			2: lead = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
			default: begin
				case ($urandom_range(3))
					0: lead = LEAD3_LO;
					1: lead = LEAD3_SURR;
					2: lead = LEAD4_LO;
					default: lead = LEAD4_HI;
				endcase
			end
		endcase
		span = (lead >= LEAD4_LO) ? 3 : (lead >= LEAD3_LO) ? 2 : 1;
		lo   = (lead == LEAD3_LO) ? E0_SECOND_LO : (lead == LEAD4_LO) ? F0_SECOND_LO : CONT_LO;
		hi   = (lead == LEAD3_SURR) ? ED_SECOND_HI : (lead == LEAD4_HI) ? F4_SECOND_HI : CONT_HI;
		// most runs complete; the rest stop short, often on a random byte
		keep = (r < 85) ? span : $urandom_range(span - 1, 0);
		run.insert(run.size(), lead);
		for (int i = 0; i < keep; i++)
			run.insert(run.size(), i == 0 ? pick_in(lo, hi) : pick_in(CONT_LO, CONT_HI));
		if (keep < span && $urandom_range(1))
			run.insert(run.size(), 8'($urandom_range(255)));
		foreach (run[i]) begin
			// hold the prefix over an empty item now and then
			if (i > 0 && $urandom_range(99) < 4)
				add_item(8'($urandom_range(255)), 1'b0, 1'b0);
			add_item(run[i], 1'b1, fin && i == run.size() - 1);
		end
	endfunction

	task automatic write_fatal(logic v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// Wait until every item is taken and every result is back
	task automatic drain();
		@(negedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			void'(pending_items.pop_front());
			send_gap = pick_gap();
		end
		// hold an offered item until taken, then idle or offer the next
		if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pending_items[0].b;
				s_axis_tuser  <= pending_items[0].has;
				s_axis_tlast  <= pending_items[0].fin;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result side ready: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_wanted && !hold_done) begin
			hold_done = 1'b1;
			sink_stall = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (sink_stall > 0) begin
			sink_stall--;
			m_axis_tready <= 1'b0;
		end else if (!calm_phase && $urandom_range(99) < 20) begin
			sink_stall = pick_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- monitor

	function automatic void note_mismatch(string what, result_t want, result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected cp %06h st %0d last %0b, got cp %06h st %0d last %0b",
				what, want.cp, want.st, want.last, got.cp, got.st, got.last);
	endfunction

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n) begin
			if (cfg_we)
				dec_fatal = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				decode_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got.cp   = m_axis_tdata[20:0];
				got.st   = status_t'(m_axis_tuser);
				got.last = m_axis_tlast;
				if (expected_results.size() == 0) begin
					note_mismatch("unexpected result", '0, got);
				end else begin
					want = expected_results.pop_front();
					if (got != want)
						note_mismatch("wrong result", want, got);
				end
			end
		end
	end

	// Give up at the cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Substitution mode: range edges, bad leads, split subparts, finish cases
		write_fatal(1'b0);
		add_item(8'h00, 1'b1, 1'b0);
		add_item(8'h7F, 1'b1, 1'b0);
		add_item(8'hDF, 1'b1, 1'b0);
		add_item(8'hBF, 1'b1, 1'b0);
		add_item(8'hE0, 1'b1, 1'b0);
		add_item(8'hA0, 1'b1, 1'b0);
		add_item(8'h80, 1'b1, 1'b0);
		add_item(8'hED, 1'b1, 1'b0);
		add_item(8'h9F, 1'b1, 1'b0);
		add_item(8'hBF, 1'b1, 1'b0);
		add_item(8'hF4, 1'b1, 1'b0);
		add_item(8'h8F, 1'b1, 1'b0);
		add_item(8'hBF, 1'b1, 1'b0);
		add_item(8'hBF, 1'b1, 1'b0);
		add_item(8'h80, 1'b1, 1'b0);
		add_item(8'hFF, 1'b1, 1'b0);
		add_item(8'hE0, 1'b1, 1'b0);
		add_item(8'h80, 1'b1, 1'b0);
		add_item(8'hF0, 1'b1, 1'b0);
		add_item(8'h90, 1'b1, 1'b1);
		add_item(8'hE1, 1'b1, 1'b0);
		add_item(8'h55, 1'b0, 1'b0);
		add_item(8'hAA, 1'b0, 1'b1);
		drain();

		// Fatal mode: failure, items ignored until finish, failure on a bare finish
		write_fatal(1'b1);
		add_item(8'h41, 1'b1, 1'b0);
		add_item(8'hC2, 1'b1, 1'b0);
		add_item(8'h41, 1'b1, 1'b0);
		add_item(8'h42, 1'b1, 1'b0);
		add_item(8'hF5, 1'b1, 1'b1);
		add_item(8'hE1, 1'b1, 1'b0);
		add_item(8'h00, 1'b0, 1'b1);
		add_item(8'hFF, 1'b1, 1'b0);
		drain();

		// Failure sticks after leaving fatal mode until the next finish
		write_fatal(1'b0);
		add_item(8'h41, 1'b1, 1'b0);
		add_item(8'h41, 1'b1, 1'b1);
		drain();

		// Random phases: long hold-off, normal traffic, no idling, fatal mode
		for (int p = 0; p < 4; p++) begin
			write_fatal(p[0]);
			calm_phase  = (p == 2);
			hold_wanted = (p == 0);
			while (pending_items.size() < (p[0] ? 260 : 200))
				add_random_run(p[0] ? 30 : 8);
			drain();
		end

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
